### hdl/rbi_pkg.sv
// ============================================================================
// rbi_pkg
// Shared types and constants for the ray/box intersection pipeline.
// ============================================================================
package rbi_pkg;

    localparam int CW     = 32;          // coordinate width
    localparam int NW     = CW + 1;      // plane offset width
    localparam int DW     = CW;          // denominator width
    localparam int MW     = 2 * CW;      // product magnitude width
    localparam int QW     = 34;          // quotient bits kept by the divider
    localparam int FACES  = 6;
    localparam int AXES   = 3;

    localparam int LANE_LAT  = QW + 3;           // s1, s2, divider cells, post
    localparam int SEL_LAT   = 2 * FACES;        // two stages per select cell
    localparam int PIPE_LAST = LANE_LAT + SEL_LAT + 1;

    localparam logic [19:0] T_LIMIT = 20'd1000000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [NW-1:0] num_t;
    typedef logic        [DW-1:0] den_t;

    typedef enum logic [2:0] {
        FACE_NEG_X = 3'd0,
        FACE_NEG_Y = 3'd1,
        FACE_NEG_Z = 3'd2,
        FACE_POS_X = 3'd3,
        FACE_POS_Y = 3'd4,
        FACE_POS_Z = 3'd5,
        FACE_NONE  = 3'd6
    } face_t;

    typedef enum logic [2:0] {
        REG_LOW_X   = 3'd0,
        REG_HIGH_X  = 3'd1,
        REG_LOW_Y   = 3'd2,
        REG_HIGH_Y  = 3'd3,
        REG_LOW_Z   = 3'd4,
        REG_HIGH_Z  = 3'd5,
        REG_MIN_DEN = 3'd6
    } cfg_reg_t;

    // one restoring-division step state
    typedef struct packed {
        den_t          den;
        logic [DW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
    } div_t;

    // candidate face after the bounds test; pt in x, y, z order at the top
    typedef struct packed {
        logic                ok;
        num_t                num;
        den_t                den;
        coord_t [AXES-1:0]   pt;
    } cand_t;

    typedef struct packed {
        logic                found;
        num_t                num;
        den_t                den;
        face_t               face;
        coord_t [AXES-1:0]   pt;
    } best_t;

endpackage

### hdl/ray_box_intersect_top.sv
// ============================================================================
// ray_box_intersect_top
// Ray against axis-aligned box test, fully pipelined, one ray per cycle when not stalled.
// ============================================================================
// Usage:
//   Load the box bounds and min_denominator through the cfg channel
//   (cfg_index 0..6, cfg_ready is always high) while no ray is in flight.
//   Rays enter on in_valid/in_ready; one result item leaves per ray on
//   out_valid/out_ready, in order.
// Throughput: one ray per cycle when not stalled; the six face lanes run
//   side by side, each with two 34-cell restoring divider chains, followed
//   by a chain of six select cells.
// Stall: the whole pipe holds while a result waits in the output register
//   and the last stage is full; bubbles still advance, so new rays are
//   taken while a result waits.
// Reset: bounds clear to 0, min_denominator to 1, all valids drop.
// A miss gives hit = 0 and zero coordinates; face still names the face
//   accepted when only the t limit failed, else FACE_NONE.
// ============================================================================
module ray_box_intersect_top
    import rbi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  coord_t      origin_x,
    input  coord_t      origin_y,
    input  coord_t      origin_z,
    input  coord_t      dir_x,
    input  coord_t      dir_y,
    input  coord_t      dir_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output coord_t      hit_x,
    output coord_t      hit_y,
    output coord_t      hit_z,
    output logic [2:0]  face
);

    // configuration registers
    coord_t      lo_reg [AXES];
    coord_t      hi_reg [AXES];
    logic [30:0] min_den_reg;

    // input stage
    coord_t      p_reg [AXES];
    coord_t      v_reg [AXES];

    logic [PIPE_LAST:0] vld_reg;
    logic               en;

    cand_t lane_out [FACES];
    cand_t cand0    [FACES];
    cand_t cand_reg [1:SEL_LAT-2][FACES];
    best_t best_chain [FACES+1];

    best_t          lim_best_reg;
    logic [51:0]    lim_prod_reg;
    logic           over;

    logic   out_valid_reg;
    logic   hit_reg;
    coord_t hx_reg, hy_reg, hz_reg;
    face_t  face_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                lo_reg[k] <= '0;
                hi_reg[k] <= '0;
            end
            min_den_reg <= 31'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOW_X:   lo_reg[0]   <= cfg_data;
                REG_HIGH_X:  hi_reg[0]   <= cfg_data;
                REG_LOW_Y:   lo_reg[1]   <= cfg_data;
                REG_HIGH_Y:  hi_reg[1]   <= cfg_data;
                REG_LOW_Z:   lo_reg[2]   <= cfg_data;
                REG_HIGH_Z:  hi_reg[2]   <= cfg_data;
                REG_MIN_DEN: min_den_reg <= cfg_data[30:0];
                default:     ;
            endcase
        end
    end

    // advance unless the last stage is full and the output is still held
    assign en       = out_ready || !out_valid_reg || !vld_reg[PIPE_LAST];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= origin_x;
            p_reg[1] <= origin_y;
            p_reg[2] <= origin_z;
            v_reg[0] <= dir_x;
            v_reg[1] <= dir_y;
            v_reg[2] <= dir_z;
        end
    end

    // six face lanes: -X, -Y, -Z on the low planes, +X, +Y, +Z on the high
    for (genvar f = 0; f < FACES; f++)
    begin : g_lane
        localparam int A = f % AXES;
        localparam int U = (A + 1) % AXES;
        localparam int W = (A + 2) % AXES;

        rbi_face_lane u_lane (
            .clk     (clk),
            .en      (en),
            .min_den (min_den_reg),
            .plane   ((f < AXES) ? lo_reg[A] : hi_reg[A]),
            .lo_u    (lo_reg[U]),
            .hi_u    (hi_reg[U]),
            .lo_w    (lo_reg[W]),
            .hi_w    (hi_reg[W]),
            .p_a     (p_reg[A]),
            .p_u     (p_reg[U]),
            .p_w     (p_reg[W]),
            .v_a     (v_reg[A]),
            .v_u     (v_reg[U]),
            .v_w     (v_reg[W]),
            .cand    (lane_out[f])
        );

        // put the lane's point back in x, y, z order
        always_comb
        begin
            cand0[f]       = lane_out[f];
            cand0[f].pt[A] = lane_out[f].pt[0];
            cand0[f].pt[U] = lane_out[f].pt[1];
            cand0[f].pt[W] = lane_out[f].pt[2];
        end
    end

    // delay the candidates so each select cell meets its own face
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg[1] <= cand0;
            for (int j = 2; j <= SEL_LAT - 2; j++)
            begin
                cand_reg[j] <= cand_reg[j-1];
            end
        end
    end

    always_comb
    begin
        best_chain[0]       = '0;
        best_chain[0].den   = den_t'(1);
        best_chain[0].face  = FACE_NONE;
    end

    for (genvar f = 0; f < FACES; f++)
    begin : g_sel
        cand_t c_in;
        if (f == 0)
        begin : g_first
            assign c_in = cand0[0];
        end
        else
        begin : g_rest
            assign c_in = cand_reg[2*f][f];
        end

        rbi_sel_cell u_sel (
            .clk       (clk),
            .en        (en),
            .face_code (face_t'(3'(f))),
            .cand_in   (c_in),
            .best_in   (best_chain[f]),
            .best_out  (best_chain[f+1])
        );
    end

    // parameter limit: scale the denominator, compare in the output stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lim_best_reg <= best_chain[FACES];
            lim_prod_reg <= 52'(T_LIMIT) * 52'(best_chain[FACES].den);
        end
    end

    assign over = $signed(53'(lim_best_reg.num)) > $signed({1'b0, lim_prod_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            out_valid_reg <= vld_reg[PIPE_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            hit_reg  <= lim_best_reg.found && !over;
            hx_reg   <= (lim_best_reg.found && !over) ? lim_best_reg.pt[0] : '0;
            hy_reg   <= (lim_best_reg.found && !over) ? lim_best_reg.pt[1] : '0;
            hz_reg   <= (lim_best_reg.found && !over) ? lim_best_reg.pt[2] : '0;
            face_reg <= lim_best_reg.face;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_x     = hx_reg;
    assign hit_y     = hy_reg;
    assign hit_z     = hz_reg;
    assign face      = face_reg;

    // a miss reports a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (hit_x == '0) && (hit_y == '0) && (hit_z == '0))
        else $error("miss with nonzero point");

    // a hit always names a face
    a_hit_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> face != FACE_NONE)
        else $error("hit without face");

    // full tail and held output must block new rays
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE_LAST] && out_valid && !out_ready |-> !in_ready)
        else $error("ray accepted while pipe is blocked");

endmodule

### hdl/rbi_div_cell.sv
// ============================================================================
// rbi_div_cell
// One restoring-division step: shift in a dividend bit, trial subtract.
// ============================================================================
module rbi_div_cell
    import rbi_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    div_t        d_reg;
    div_t        d_next;
    logic [DW:0] shifted;
    logic [DW:0] diff;

    always_comb
    begin
        shifted = {d_in.rem, d_in.low[QW-1]};
        diff    = shifted - {1'b0, d_in.den};
        d_next  = d_in;
        d_next.low = {d_in.low[QW-2:0], 1'b0};
        if (!diff[DW])
        begin
            d_next.rem = diff[DW-1:0];
            d_next.quo = {d_in.quo[QW-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = shifted[DW-1:0];
            d_next.quo = {d_in.quo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

### hdl/rbi_face_lane.sv
// ============================================================================
// rbi_face_lane
// One face: plane offset, two products, two divider chains, bounds test.
// ============================================================================
module rbi_face_lane
    import rbi_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [30:0]   min_den,
    input  coord_t        plane,
    input  coord_t        lo_u,
    input  coord_t        hi_u,
    input  coord_t        lo_w,
    input  coord_t        hi_w,
    input  coord_t        p_a,
    input  coord_t        p_u,
    input  coord_t        p_w,
    input  coord_t        v_a,
    input  coord_t        v_u,
    input  coord_t        v_w,
    output cand_t         cand
);

    typedef struct packed {
        logic   try_ok;
        num_t   num;
        den_t   den;
        coord_t pu;
        coord_t pw;
        coord_t plane;
        logic   su;
        logic   sw;
        logic   ovu;
        logic   ovw;
    } side_t;

    // stage 1
    logic   s1_try_reg;
    num_t   s1_num_reg;
    den_t   s1_den_reg;
    coord_t s1_pu_reg, s1_pw_reg, s1_vu_reg, s1_vw_reg, s1_plane_reg;
    logic   s1_try_next;
    num_t   s1_num_next, diff;
    den_t   s1_den_next;

    // stage 2
    logic   s2_try_reg;
    num_t   s2_num_reg;
    den_t   s2_den_reg;
    coord_t s2_pu_reg, s2_pw_reg, s2_plane_reg;
    logic signed [MW:0] s2_prod_u_reg, s2_prod_w_reg;

    logic signed [MW:0] neg_u, neg_w;
    logic [MW-1:0]      mag_u, mag_w;
    side_t              side_init;
    side_t              side_reg [QW];
    div_t               chain_u [QW+1];
    div_t               chain_w [QW+1];

    side_t              sd;
    logic signed [QW+1:0] q_u, q_w, b_u, b_w;
    logic               in_u, in_w;
    cand_t              cand_reg, cand_next;

    // offset, denominator and skip test
    always_comb
    begin
        diff        = NW'(plane) - NW'(p_a);
        s1_num_next = v_a[CW-1] ? -diff : diff;
        s1_den_next = v_a[CW-1] ? den_t'(-v_a) : den_t'(v_a);
        s1_try_next = (v_a != '0) && (s1_den_next >= {1'b0, min_den});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_try_reg    <= s1_try_next;
            s1_num_reg    <= s1_num_next;
            s1_den_reg    <= s1_den_next;
            s1_pu_reg     <= p_u;
            s1_pw_reg     <= p_w;
            s1_vu_reg     <= v_u;
            s1_vw_reg     <= v_w;
            s1_plane_reg  <= plane;
            s2_try_reg    <= s1_try_reg;
            s2_num_reg    <= s1_num_reg;
            s2_den_reg    <= s1_den_reg;
            s2_pu_reg     <= s1_pu_reg;
            s2_pw_reg     <= s1_pw_reg;
            s2_plane_reg  <= s1_plane_reg;
            s2_prod_u_reg <= (MW+1)'(s1_vu_reg) * (MW+1)'(s1_num_reg);
            s2_prod_w_reg <= (MW+1)'(s1_vw_reg) * (MW+1)'(s1_num_reg);
        end
    end

    // magnitudes feed the divider chains; the quotient overflow check joins the face data
    always_comb
    begin
        neg_u = -s2_prod_u_reg;
        neg_w = -s2_prod_w_reg;
        mag_u = s2_prod_u_reg[MW] ? neg_u[MW-1:0] : s2_prod_u_reg[MW-1:0];
        mag_w = s2_prod_w_reg[MW] ? neg_w[MW-1:0] : s2_prod_w_reg[MW-1:0];

        chain_u[0].den = s2_den_reg;
        chain_u[0].rem = DW'(mag_u[MW-1:QW]);
        chain_u[0].low = mag_u[QW-1:0];
        chain_u[0].quo = '0;
        chain_w[0].den = s2_den_reg;
        chain_w[0].rem = DW'(mag_w[MW-1:QW]);
        chain_w[0].low = mag_w[QW-1:0];
        chain_w[0].quo = '0;

        side_init.try_ok = s2_try_reg;
        side_init.num    = s2_num_reg;
        side_init.den    = s2_den_reg;
        side_init.pu     = s2_pu_reg;
        side_init.pw     = s2_pw_reg;
        side_init.plane  = s2_plane_reg;
        side_init.su     = s2_prod_u_reg[MW];
        side_init.sw     = s2_prod_w_reg[MW];
        side_init.ovu    = DW'(mag_u[MW-1:QW]) >= s2_den_reg;
        side_init.ovw    = DW'(mag_w[MW-1:QW]) >= s2_den_reg;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        rbi_div_cell u_cell_u (.clk(clk), .en(en), .d_in(chain_u[i]), .d_out(chain_u[i+1]));
        rbi_div_cell u_cell_w (.clk(clk), .en(en), .d_in(chain_w[i]), .d_out(chain_w[i+1]));
    end

    // hold the face data alongside the divider cells
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_init;
            for (int j = 1; j < QW; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // signed quotient, hit coordinates, inclusive bounds test
    always_comb
    begin
        sd  = side_reg[QW-1];
        q_u = sd.su ? -$signed({2'b00, chain_u[QW].quo}) : $signed({2'b00, chain_u[QW].quo});
        q_w = sd.sw ? -$signed({2'b00, chain_w[QW].quo}) : $signed({2'b00, chain_w[QW].quo});
        b_u = (QW+2)'(sd.pu) + q_u;
        b_w = (QW+2)'(sd.pw) + q_w;
        in_u = !sd.ovu && (b_u >= (QW+2)'(lo_u)) && (b_u <= (QW+2)'(hi_u));
        in_w = !sd.ovw && (b_w >= (QW+2)'(lo_w)) && (b_w <= (QW+2)'(hi_w));

        cand_next.ok    = sd.try_ok && in_u && in_w;
        cand_next.num   = sd.num;
        cand_next.den   = sd.den;
        cand_next.pt[0] = sd.plane;
        cand_next.pt[1] = b_u[CW-1:0];
        cand_next.pt[2] = b_w[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand = cand_reg;

endmodule

### hdl/rbi_sel_cell.sv
// ============================================================================
// rbi_sel_cell
// Fold one candidate face into the running best: cross-product compare.
// ============================================================================
module rbi_sel_cell
    import rbi_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  face_t face_code,
    input  cand_t cand_in,
    input  best_t best_in,
    output best_t best_out
);

    best_t                a_best_reg;
    cand_t                a_cand_reg;
    logic signed [2*NW-1:0] a_pc_reg, a_pb_reg;
    best_t                b_best_reg, b_best_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_best_reg <= best_in;
            a_cand_reg <= cand_in;
            a_pc_reg   <= (2*NW)'(cand_in.num) * (2*NW)'($signed({1'b0, best_in.den}));
            a_pb_reg   <= (2*NW)'(best_in.num) * (2*NW)'($signed({1'b0, cand_in.den}));
            b_best_reg <= b_best_next;
        end
    end

    always_comb
    begin
        b_best_next = a_best_reg;
        if (a_cand_reg.ok && (!a_best_reg.found || (a_pc_reg < a_pb_reg)))
        begin
            b_best_next.found = 1'b1;
            b_best_next.num   = a_cand_reg.num;
            b_best_next.den   = a_cand_reg.den;
            b_best_next.face  = face_code;
            b_best_next.pt    = a_cand_reg.pt;
        end
    end

    assign best_out = b_best_reg;

endmodule
